// ===== design/sbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sbe_pkg
// Request codes and transfer payload types for the selection bitmask engine.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam logic [3:0] REQ_INIT       = 4'd0;
  localparam logic [3:0] REQ_INSERT     = 4'd1;
  localparam logic [3:0] REQ_DELETE     = 4'd2;
  localparam logic [3:0] REQ_SELECT     = 4'd3;
  localparam logic [3:0] REQ_DESELECT   = 4'd4;
  localparam logic [3:0] REQ_INVERT     = 4'd5;
  localparam logic [3:0] REQ_CLEAR      = 4'd6;
  localparam logic [3:0] REQ_SELECT_ALL = 4'd7;
  localparam logic [3:0] REQ_FIND_NEXT  = 4'd8;

  typedef struct packed {
    logic [3:0] req_type;
    logic [4:0] index;
    logic [5:0] object_count_in;
    logic       redraw_enable;
  } in_item_t;

  typedef struct packed {
    logic [31:0] redraw_mask;
    logic [31:0] selection_bits;
    logic [5:0]  selected_count;
    logic [5:0]  object_count;
    logic        found;
    logic [4:0]  found_index;
    logic        error;
  } out_item_t;

endpackage

// ===== design/sbe_find.sv =====
// ----------------------------------------------------------------------------
// sbe_find
// Priority encoder: position of the lowest set bit of a candidate vector.
// ----------------------------------------------------------------------------
module sbe_find #(
  parameter int MAX_OBJECTS = 32
) (
  input  logic [MAX_OBJECTS-1:0]         rest,
  output logic                           hit,
  output logic [$clog2(MAX_OBJECTS)-1:0] pos
);

  localparam int PW = $clog2(MAX_OBJECTS);

  assign hit = |rest;

  // scan from the top so the lowest set bit wins
  always_comb begin
    pos = '0;
    for (int i = MAX_OBJECTS - 1; i >= 0; i--) begin
      if (rest[i]) begin
        pos = PW'(i);
      end
    end
  end

endmodule

// ===== design/sbe_update.sv =====
// ----------------------------------------------------------------------------
// sbe_update
// Next-state and result logic for one request against the selection state.
// ----------------------------------------------------------------------------
module sbe_update import sbe_pkg::*; #(
  parameter int MAX_OBJECTS = 32
) (
  input  in_item_t                             req,
  input  logic [MAX_OBJECTS-1:0]               vec_cur,
  input  logic [$clog2(MAX_OBJECTS+1)-1:0]     sel_cur,
  input  logic [$clog2(MAX_OBJECTS+1)-1:0]     obj_cur,
  output logic [MAX_OBJECTS-1:0]               vec_next,
  output logic [$clog2(MAX_OBJECTS+1)-1:0]     sel_next,
  output logic [$clog2(MAX_OBJECTS+1)-1:0]     obj_next,
  output out_item_t                            res
);

  localparam int CW = $clog2(MAX_OBJECTS + 1);
  localparam int PW = $clog2(MAX_OBJECTS);
  // compare width: holds MAX_OBJECTS, any count and any 6-bit input
  localparam int WW = ((CW > 6) ? CW : 6) + 1;

  logic [WW-1:0]          idx_w;
  logic [WW-1:0]          obj_w;
  logic [WW-1:0]          cnt_w;
  logic [WW-1:0]          max_w;
  logic [MAX_OBJECTS-1:0] bit_mask;
  logic [MAX_OBJECTS-1:0] lo_mask;
  logic [MAX_OBJECTS-1:0] obj_mask;
  logic [MAX_OBJECTS-1:0] rest;
  logic [MAX_OBJECTS-1:0] redraw;
  logic                   idx_ok;
  logic                   was;
  logic                   flip;
  logic                   hit;
  logic [PW-1:0]          pos;
  logic                   found;
  logic                   err;

  assign idx_w = WW'(req.index);
  assign obj_w = WW'(obj_cur);
  assign cnt_w = WW'(req.object_count_in);
  assign max_w = WW'(MAX_OBJECTS);

  always_comb begin
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      bit_mask[i] = (WW'(i) == idx_w);
      lo_mask[i]  = (WW'(i) < idx_w);
      obj_mask[i] = (WW'(i) < obj_w);
    end
  end

  assign idx_ok = (idx_w < obj_w);
  assign was    = |(vec_cur & bit_mask);
  assign rest   = vec_cur & obj_mask & ~lo_mask;

  sbe_find #(
    .MAX_OBJECTS(MAX_OBJECTS)
  ) u_find (
    .rest(rest),
    .hit (hit),
    .pos (pos)
  );

  always_comb begin
    vec_next = vec_cur;
    sel_next = sel_cur;
    obj_next = obj_cur;
    redraw   = '0;
    found    = 1'b0;
    err      = 1'b0;
    flip     = 1'b0;
    case (req.req_type)
      REQ_INIT: begin
        if (cnt_w > max_w) begin
          err = 1'b1;
        end else begin
          vec_next = '0;
          sel_next = '0;
          obj_next = CW'(req.object_count_in);
        end
      end
      REQ_INSERT: begin
        if (obj_w >= max_w || idx_w > obj_w) begin
          err = 1'b1;
        end else begin
          vec_next = (vec_cur & lo_mask) | ((vec_cur & ~lo_mask) << 1);
          obj_next = obj_cur + CW'(1);
        end
      end
      REQ_DELETE: begin
        if (!idx_ok) begin
          err = 1'b1;
        end else begin
          vec_next = (vec_cur & lo_mask) | ((vec_cur & ~lo_mask & ~bit_mask) >> 1);
          obj_next = obj_cur - CW'(1);
          if (was) begin
            sel_next = sel_cur - CW'(1);
          end
        end
      end
      REQ_SELECT, REQ_DESELECT, REQ_INVERT: begin
        if (!idx_ok) begin
          err = 1'b1;
        end else begin
          flip = (req.req_type == REQ_INVERT) ||
                 (req.req_type == REQ_SELECT && !was) ||
                 (req.req_type == REQ_DESELECT && was);
          if (flip) begin
            vec_next = vec_cur ^ bit_mask;
            sel_next = was ? (sel_cur - CW'(1)) : (sel_cur + CW'(1));
            if (req.req_type != REQ_INVERT || req.redraw_enable) begin
              redraw = bit_mask;
            end
          end
        end
      end
      REQ_CLEAR: begin
        redraw   = vec_cur & obj_mask;
        vec_next = '0;
        sel_next = '0;
      end
      REQ_SELECT_ALL: begin
        redraw   = ~vec_cur & obj_mask;
        vec_next = obj_mask;
        sel_next = obj_cur;
      end
      REQ_FIND_NEXT: begin
        found = idx_ok && hit;
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  assign res.redraw_mask    = 32'(redraw);
  assign res.selection_bits = 32'(vec_next);
  assign res.selected_count = 6'(sel_next);
  assign res.object_count   = 6'(obj_next);
  assign res.found          = found;
  assign res.found_index    = found ? 5'(pos) : 5'd0;
  assign res.error          = err;

endmodule

// ===== design/selection_bitmask_engine.sv =====
// ----------------------------------------------------------------------------
// selection_bitmask_engine
// Selection bit vector over an ordered object list, one request per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready/in_data, one result per request
//   leaves on out_valid/out_ready/out_data, both valid/ready channels.
//   A request is captured in an input register; from there it is applied
//   to the selection state and its result is loaded into the output register.
//   Throughput: 1 request per cycle while the receiver does not stall,
//   set by the single update pass between the input register and the
//   output register.
//   While the receiver stalls, the finished result holds in the output
//   register, one more request waits in the input register, and in_ready
//   drops only once both are full.
//   Reset (rst, synchronous) empties both registers and clears the vector
//   and both counts; no initialization sweep is needed. in_ready is low
//   while rst is high.
//   Refused requests report error with the state left unchanged.
// ----------------------------------------------------------------------------
module selection_bitmask_engine import sbe_pkg::*; #(
  parameter int MAX_OBJECTS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(MAX_OBJECTS + 1);

  logic                   s1_valid;
  in_item_t               s1_item;
  logic [MAX_OBJECTS-1:0] vec;
  logic [CW-1:0]          sel_total;
  logic [CW-1:0]          obj_total;
  logic [MAX_OBJECTS-1:0] vec_next;
  logic [CW-1:0]          sel_total_next;
  logic [CW-1:0]          obj_total_next;
  out_item_t              res;
  logic                   adv;

  // stage 1 moves to the output register when that register is free or draining
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || adv);

  sbe_update #(
    .MAX_OBJECTS(MAX_OBJECTS)
  ) u_update (
    .req     (s1_item),
    .vec_cur (vec),
    .sel_cur (sel_total),
    .obj_cur (obj_total),
    .vec_next(vec_next),
    .sel_next(sel_total_next),
    .obj_next(obj_total_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      vec       <= '0;
      sel_total <= '0;
      obj_total <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
        vec       <= vec_next;
        sel_total <= sel_total_next;
        obj_total <= obj_total_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
    if (adv) begin
      out_data <= res;
    end
  end

endmodule
